[hw/rtl/cursor_list_engine_macros.svh]
// assertion macros used by the list engine port checker
`ifndef CURSOR_LIST_ENGINE_MACROS_SVH
`define CURSOR_LIST_ENGINE_MACROS_SVH

// same-cycle implication, held off during reset
`define CLE_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("cursor list engine check failed");

// next-cycle implication, held off during reset
`define CLE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("cursor list engine check failed");

`endif

[hw/rtl/cle_pkg.sv]
// types and codes shared by the cursor list engine modules
package cle_pkg;

    typedef enum logic [3:0] {
        OP_INSERT  = 4'd0,
        OP_REMOVE  = 4'd1,
        OP_REPLACE = 4'd2,
        OP_CLEAR   = 4'd3,
        OP_BEGIN   = 4'd4,
        OP_END     = 4'd5,
        OP_NEXT    = 4'd6,
        OP_PRIOR   = 4'd7,
        OP_MOVE    = 4'd8,
        OP_FIND    = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_AT_END   = 3'd3,
        ST_AT_BEGIN = 3'd4,
        ST_RANGE    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2,
        SEL_DIN   = 2'd3
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      cmp_en;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

[hw/rtl/cursor_list_engine.sv]
// cursor list engine: a row of item cells with a cursor, one operation per request
// a request steps from the execute state to the done state; a find on a non-empty list scans between them
// one request at a time: a new one is taken only in the idle state, after the result is loaded;
//   the find scan walks the registered match bits one cell per cycle
// a finished result waits in the output register while the next request is taken
// reset clears count, cursor, control and output valid; cell contents stay undefined
module cursor_list_engine
    import cle_pkg::*;
#(
    parameter int MAX_ITEMS  = 16,
    parameter int ITEM_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            operation,
    input  logic [ITEM_WIDTH-1:0] data_item,
    input  logic [3:0]            position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic                  found,
    output logic [ITEM_WIDTH-1:0] cursor_item,
    output logic [3:0]            cursor_position,
    output logic [4:0]            item_count
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int PW    = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ITEMS);

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [ITEM_WIDTH-1:0] data_reg, data_next;
    logic [3:0]            pos_reg, pos_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      cursor_reg, cursor_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [MAX_ITEMS-1:0]  hit_reg, hit_next;
    status_t               res_status_reg, res_status_next;
    logic                  res_found_reg, res_found_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic                  out_found_reg, out_found_next;
    logic [ITEM_WIDTH-1:0] out_item_reg, out_item_next;
    logic [3:0]            out_pos_reg, out_pos_next;
    logic [4:0]            out_count_reg, out_count_next;

    logic [ITEM_WIDTH-1:0] item_arr [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]  hit_vec;
    cell_ctl_t             ctl_arr [MAX_ITEMS];
    logic [ITEM_WIDTH-1:0] cur_item;
    logic [ITEM_WIDTH-1:0] din_bus;
    logic [CNT_W-1:0]      c_ext;
    logic [CNT_W-1:0]      p_ext;
    logic [IDX_W-1:0]      p_idx;
    logic                  empty;
    logic                  pos_ok;
    logic                  in_take;
    logic                  out_load;

    assign in_take  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign empty    = (count_reg == '0);
    assign c_ext    = CNT_W'(cursor_reg);
    assign pos_ok   = (PW'(pos_reg) < PW'(count_reg));
    assign p_idx    = IDX_W'(pos_reg);
    assign p_ext    = CNT_W'(p_idx);
    assign cur_item = item_arr[cursor_reg];
    // a move reinserts the cursor item, everything else writes the request data
    assign din_bus  = (op_reg == OP_MOVE) ? cur_item : data_reg;

    // per-cell shift control, only in the execute cycle
    for (genvar k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        localparam logic [CNT_W-1:0] K = CNT_W'(k);
        logic [ITEM_WIDTH-1:0] left_item;
        logic [ITEM_WIDTH-1:0] right_item;

        always_comb
        begin
            ctl_arr[k].sel    = SEL_HOLD;
            ctl_arr[k].cmp_en = (state_reg == S_EXEC);
            if (state_reg == S_EXEC)
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (empty)
                        begin
                            if (K == '0)
                                ctl_arr[k].sel = SEL_DIN;
                        end
                        else if (count_reg != FULL_CNT)
                        begin
                            if (K == c_ext + 1'b1)
                                ctl_arr[k].sel = SEL_DIN;
                            else if ((K > c_ext) && (K <= count_reg))
                                ctl_arr[k].sel = SEL_LEFT;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!empty && (K >= c_ext) && (K + 1'b1 < count_reg))
                            ctl_arr[k].sel = SEL_RIGHT;
                    end
                    OP_REPLACE:
                    begin
                        if (!empty && (K == c_ext))
                            ctl_arr[k].sel = SEL_DIN;
                    end
                    OP_MOVE:
                    begin
                        if (pos_ok)
                        begin
                            if (K == p_ext)
                                ctl_arr[k].sel = SEL_DIN;
                            else if ((c_ext < p_ext) && (K >= c_ext) && (K < p_ext))
                                ctl_arr[k].sel = SEL_RIGHT;
                            else if ((c_ext > p_ext) && (K > p_ext) && (K <= c_ext))
                                ctl_arr[k].sel = SEL_LEFT;
                        end
                    end
                    default:
                    begin
                        ctl_arr[k].sel = SEL_HOLD;
                    end
                endcase
            end
        end

        if (k == 0)
        begin : g_first
            assign left_item = '0;
        end
        else
        begin : g_mid_l
            assign left_item = item_arr[k-1];
        end

        if (k == MAX_ITEMS - 1)
        begin : g_last
            assign right_item = '0;
        end
        else
        begin : g_mid_r
            assign right_item = item_arr[k+1];
        end

        cle_cell #(
            .ITEM_WIDTH (ITEM_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl_arr[k]),
            .left_item  (left_item),
            .right_item (right_item),
            .din        (din_bus),
            .key        (data_reg),
            .item       (item_arr[k]),
            .hit        (hit_vec[k])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        data_next       = data_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        scan_next       = scan_reg;
        hit_next        = hit_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = op_t'(operation);
                    data_next  = data_item;
                    pos_next   = position;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_found_next  = 1'b0;
                state_next      = S_DONE;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg == FULL_CNT)
                            res_status_next = ST_FULL;
                        else if (empty)
                        begin
                            cursor_next = '0;
                            count_next  = CNT_W'(1);
                        end
                        else
                        begin
                            cursor_next = cursor_reg + 1'b1;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (empty)
                            res_status_next = ST_EMPTY;
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            if (cursor_reg != '0)
                                cursor_next = cursor_reg - 1'b1;
                        end
                    end
                    OP_REPLACE:
                    begin
                        if (empty)
                            res_status_next = ST_EMPTY;
                    end
                    OP_CLEAR:
                    begin
                        count_next  = '0;
                        cursor_next = '0;
                    end
                    OP_BEGIN:
                    begin
                        if (empty)
                            res_status_next = ST_EMPTY;
                        else
                            cursor_next = '0;
                    end
                    OP_END:
                    begin
                        if (empty)
                            res_status_next = ST_EMPTY;
                        else
                            cursor_next = IDX_W'(count_reg - 1'b1);
                    end
                    OP_NEXT:
                    begin
                        if (empty)
                            res_status_next = ST_EMPTY;
                        else if (c_ext + 1'b1 >= count_reg)
                            res_status_next = ST_AT_END;
                        else
                            cursor_next = cursor_reg + 1'b1;
                    end
                    OP_PRIOR:
                    begin
                        if (empty)
                            res_status_next = ST_EMPTY;
                        else if (cursor_reg == '0)
                            res_status_next = ST_AT_BEGIN;
                        else
                            cursor_next = cursor_reg - 1'b1;
                    end
                    OP_MOVE:
                    begin
                        if (!pos_ok)
                            res_status_next = ST_RANGE;
                        else
                            cursor_next = p_idx;
                    end
                    OP_FIND:
                    begin
                        if (empty)
                            res_status_next = ST_EMPTY;
                        else
                        begin
                            hit_next   = hit_vec;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                // first match from the start wins; no match keeps the cursor
                if (hit_reg[scan_reg])
                begin
                    cursor_next    = scan_reg;
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end
                else if (CNT_W'(scan_reg) + 1'b1 >= count_reg)
                    state_next = S_DONE;
                else
                    scan_next = scan_reg + 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_item_next   = out_item_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_found_next  = res_found_reg;
            out_item_next   = empty ? '0 : cur_item;
            out_pos_next    = empty ? 4'd0 : 4'(cursor_reg);
            out_count_next  = 5'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        data_reg       <= data_next;
        pos_reg        <= pos_next;
        scan_reg       <= scan_next;
        hit_reg        <= hit_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_item_reg   <= out_item_next;
        out_pos_reg    <= out_pos_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign found           = out_found_reg;
    assign cursor_item     = out_item_reg;
    assign cursor_position = out_pos_reg;
    assign item_count      = out_count_reg;

endmodule

[hw/rtl/cle_cell.sv]
// one list slot: holds an item, shifts to or from its neighbors, compares against a key
module cle_cell
    import cle_pkg::*;
#(
    parameter int ITEM_WIDTH = 32
)
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [ITEM_WIDTH-1:0] left_item,
    input  logic [ITEM_WIDTH-1:0] right_item,
    input  logic [ITEM_WIDTH-1:0] din,
    input  logic [ITEM_WIDTH-1:0] key,
    output logic [ITEM_WIDTH-1:0] item,
    output logic                  hit
);

    logic [ITEM_WIDTH-1:0] item_reg;
    logic [ITEM_WIDTH-1:0] item_next;

    always_comb
    begin
        case (ctl.sel)
            SEL_HOLD:  item_next = item_reg;
            SEL_LEFT:  item_next = left_item;
            SEL_RIGHT: item_next = right_item;
            SEL_DIN:   item_next = din;
            default:   item_next = item_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item = item_reg;
    assign hit  = ctl.cmp_en && (item_reg == key);

endmodule

[hw/rtl/cle_checker.sv]
// port-level checks for the cursor list engine, bound to the top level
`include "cursor_list_engine_macros.svh"

module cle_checker
    import cle_pkg::*;
#(
    parameter int MAX_ITEMS  = 16,
    parameter int ITEM_WIDTH = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [2:0]            status,
    input logic                  found,
    input logic [ITEM_WIDTH-1:0] cursor_item,
    input logic [3:0]            cursor_position,
    input logic [4:0]            item_count
);

    localparam logic [4:0] FULL_CNT = 5'(MAX_ITEMS);

    // one request at a time: a taken request closes the input for the next cycle
    `CLE_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)

    // a stalled result keeps its status, cursor item and count
    `CLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(cursor_item) && $stable(item_count))

    // an empty list shows a zero cursor and item
    `CLE_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && (item_count == 5'd0),
        (cursor_item == '0) && (cursor_position == 4'd0))

    // a full refusal only when the list is at capacity
    `CLE_ASSERT_IMPLY(a_full_cnt, clk, rst_n, out_valid && (status == ST_FULL),
        item_count == FULL_CNT)

    // a hit always reports ok on a non-empty list
    `CLE_ASSERT_IMPLY(a_found_ok, clk, rst_n, out_valid && found,
        (status == ST_OK) && (item_count != 5'd0))

endmodule

bind cursor_list_engine cle_checker #(
    .MAX_ITEMS  (MAX_ITEMS),
    .ITEM_WIDTH (ITEM_WIDTH)
) u_cle_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .found           (found),
    .cursor_item     (cursor_item),
    .cursor_position (cursor_position),
    .item_count      (item_count)
);

[dv/cle_list_checker.sv]
// watches both request and result channels, predicts each result and compares it
module cle_list_checker
    import cle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  operation,
    input  logic [31:0] data_item,
    input  logic [3:0]  position,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic        found,
    input  logic [31:0] cursor_item,
    input  logic [3:0]  cursor_position,
    input  logic [4:0]  item_count,
    output int          fail_count,
    output int          pending
);

    localparam int LIST_DEPTH = 16;

    typedef struct {
        status_t     status;
        logic        found;
        logic [31:0] item;
        logic [3:0]  cpos;
        logic [4:0]  count;
    } list_view_t;

    // shadow copy of the list
    logic [31:0] cells [LIST_DEPTH];
    int          held = 0;
    int          cur = 0;

    list_view_t  views_due [$];
    int          errors = 0;
    int          results_seen = 0;

    assign fail_count = errors;
    assign pending    = views_due.size();

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    function automatic list_view_t apply_list_op(input logic [3:0] op, input logic [31:0] d,
                                                 input logic [3:0] pos);
        list_view_t  v;
        logic [31:0] moving;
        int          i;
        v.status = ST_OK;
        v.found  = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (held >= LIST_DEPTH)
                    v.status = ST_FULL;
                else if (held == 0)
                begin
                    cells[0] = d;
                    cur = 0;
                    held = 1;
                end
                else
                begin
                    for (i = held; i > cur + 1; i--)
                        cells[i] = cells[i-1];
                    cells[cur+1] = d;
                    cur++;
                    held++;
                end
            end
            OP_REMOVE:
            begin
                if (held == 0)
                    v.status = ST_EMPTY;
                else
                begin
                    for (i = cur; i + 1 < held; i++)
                        cells[i] = cells[i+1];
                    held--;
                    if (cur > 0)
                        cur--;
                end
            end
            OP_REPLACE:
            begin
                if (held == 0)
                    v.status = ST_EMPTY;
                else
                    cells[cur] = d;
            end
            OP_CLEAR:
            begin
                held = 0;
                cur = 0;
            end
            OP_BEGIN:
            begin
                if (held == 0)
                    v.status = ST_EMPTY;
                else
                    cur = 0;
            end
            OP_END:
            begin
                if (held == 0)
                    v.status = ST_EMPTY;
                else
                    cur = held - 1;
            end
            OP_NEXT:
            begin
                if (held == 0)
                    v.status = ST_EMPTY;
                else if (cur + 1 >= held)
                    v.status = ST_AT_END;
                else
                    cur++;
            end
            OP_PRIOR:
            begin
                if (held == 0)
                    v.status = ST_EMPTY;
                else if (cur == 0)
                    v.status = ST_AT_BEGIN;
                else
                    cur--;
            end
            OP_MOVE:
            begin
                if (int'(pos) >= held)
                    v.status = ST_RANGE;
                else
                begin
                    moving = cells[cur];
                    if (cur < int'(pos))
                    begin
                        for (i = cur; i < int'(pos); i++)
                            cells[i] = cells[i+1];
                    end
                    else
                    begin
                        for (i = cur; i > int'(pos); i--)
                            cells[i] = cells[i-1];
                    end
                    cells[pos] = moving;
                    cur = pos;
                end
            end
            OP_FIND:
            begin
                if (held == 0)
                    v.status = ST_EMPTY;
                else
                begin
                    // first match from the start wins
                    for (i = 0; i < held && !v.found; i++)
                    begin
                        if (cells[i] == d)
                        begin
                            cur = i;
                            v.found = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        v.item  = (held > 0) ? cells[cur] : 32'd0;
        v.cpos  = (held > 0) ? 4'(cur) : 4'd0;
        v.count = 5'(held);
        return v;
    endfunction

    always @(posedge clk)
    begin
        list_view_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (views_due.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want = views_due.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  status, want.status));
                    if (found !== want.found)
                        report_mismatch($sformatf("found got %b expected %b",
                                                  found, want.found));
                    if (cursor_item !== want.item)
                        report_mismatch($sformatf("cursor_item got %h expected %h",
                                                  cursor_item, want.item));
                    if (cursor_position !== want.cpos)
                        report_mismatch($sformatf("cursor_position got %0d expected %0d",
                                                  cursor_position, want.cpos));
                    if (item_count !== want.count)
                        report_mismatch($sformatf("item_count got %0d expected %0d",
                                                  item_count, want.count));
                end
            end
            if (in_valid && in_ready)
                views_due.push_back(apply_list_op(operation, data_item, position));
        end
    end

endmodule

[dv/tb.sv]
// top of the list engine testbench: clock, reset, request and result drivers, verdict
module tb;
    import cle_pkg::*;

    localparam int MODE_FILL  = 0;
    localparam int MODE_MIXED = 1;
    localparam int MODE_DRAIN = 2;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  operation;
    logic [31:0] data_item;
    logic [3:0]  position;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic        found;
    logic [31:0] cursor_item;
    logic [3:0]  cursor_position;
    logic [4:0]  item_count;
    int          fail_count;
    int          pending;

    // calm turns off idling on both sides; hold_go asks for one long result stall
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    logic [31:0] recent_values [8];

    always #6 clk = ~clk;

    cursor_list_engine dut (.*);

    cle_list_checker checker_i (.*);

    task automatic send_request(input logic [3:0] op, input logic [31:0] d,
                                input logic [3:0] pos);
        while (!calm && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        data_item <= d;
        position  <= pos;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return recent_values[$urandom_range(0, 7)];
        if (r < 55)
            return $urandom_range(0, 7);
        if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hffff_ffff;
                2: return 32'h8000_0000;
                default: return 32'h7fff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    task automatic random_request(input int mode);
        int          r;
        int          ins_pct;
        int          rem_pct;
        logic [3:0]  op;
        logic [31:0] d;
        logic [3:0]  pos;
        ins_pct = (mode == MODE_FILL) ? 45 : (mode == MODE_DRAIN) ? 10 : 22;
        rem_pct = (mode == MODE_DRAIN) ? 35 : (mode == MODE_FILL) ? 6 : 15;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            op = OP_INSERT;
        else if (r < ins_pct + rem_pct)
            op = OP_REMOVE;
        else if (r < 97)
        begin
            op = 4'($urandom_range(int'(OP_REPLACE), int'(OP_FIND)));
            // keep clears rare so the list gets deep
            if (op == OP_CLEAR && $urandom_range(0, 99) < 70)
                op = OP_FIND;
        end
        else
            op = 4'($urandom_range(10, 15));
        d = pick_value();
        pos = ($urandom_range(0, 99) < 60) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 15));
        if (op == OP_INSERT || op == OP_REPLACE)
            recent_values[$urandom_range(0, 7)] = d;
        send_request(op, d, pos);
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        bit hold_used;
        int hold_left;
        hold_used = 1'b0;
        hold_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = 90;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 36);
        end
    end

    initial
    begin
        int modes [6];
        int guard;
        modes = '{MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_FILL, MODE_MIXED, MODE_DRAIN};
        guard = 0;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        operation <= 4'd0;
        data_item <= 32'd0;
        position <= 4'd0;
        foreach (recent_values[i])
            recent_values[i] = 32'd0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every operation but insert and clear on an empty list, plus an unused code
        send_request(OP_REMOVE, 32'h1111_1111, 4'd0);
        send_request(OP_REPLACE, 32'h2222_2222, 4'd0);
        send_request(OP_BEGIN, 32'd0, 4'd0);
        send_request(OP_END, 32'd0, 4'd0);
        send_request(OP_NEXT, 32'd0, 4'd0);
        send_request(OP_PRIOR, 32'd0, 4'd0);
        send_request(OP_MOVE, 32'd0, 4'd0);
        send_request(OP_FIND, 32'd0, 4'd0);
        send_request(4'd15, 32'hffff_ffff, 4'd15);
        // build a short list, walk its edges
        send_request(OP_INSERT, 32'h0000_0000, 4'd0);
        send_request(OP_INSERT, 32'hffff_ffff, 4'd0);
        send_request(OP_INSERT, 32'h5a5a_5a5a, 4'd0);
        send_request(OP_NEXT, 32'd0, 4'd0);
        send_request(OP_BEGIN, 32'd0, 4'd0);
        send_request(OP_PRIOR, 32'd0, 4'd0);
        send_request(OP_INSERT, 32'h1234_5678, 4'd0);
        send_request(OP_FIND, 32'hffff_ffff, 4'd0);
        send_request(OP_FIND, 32'hdead_beef, 4'd0);
        send_request(OP_MOVE, 32'd0, 4'd3);
        send_request(OP_MOVE, 32'd0, 4'd0);
        send_request(OP_MOVE, 32'd0, 4'd15);
        send_request(OP_END, 32'd0, 4'd0);
        send_request(OP_REPLACE, 32'ha5a5_a5a5, 4'd0);
        send_request(OP_REMOVE, 32'd0, 4'd0);
        send_request(4'd10, 32'd0, 4'd0);
        send_request(OP_CLEAR, 32'd0, 4'd0);

        for (int ph = 0; ph < 6; ph++)
        begin
            calm = (ph == 2);
            if (ph == 3)
                hold_go = 1'b1;
            if (ph == 4)
                wait_drained();
            repeat (300) random_request(modes[ph]);
        end

        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (pending != 0 && guard < 50000);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
